/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned BPA_PAGES      = 4096;
    localparam int unsigned BPA_WORD_BITS  = 64;
    localparam int unsigned BPA_PAGE_SHIFT = 12;
    localparam logic [12:0] BPA_LIMIT_RST  = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FIND  = 2'd2,
        OP_NONE  = 2'd3
    } bpa_op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [12:0] count;
        logic [11:0] start_page;
        logic [24:0] min_bytes;
    } bpa_req_t;

    typedef struct packed {
        logic        status;
        logic [11:0] page_index;
        logic [12:0] run_pages;
        logic [12:0] free_total;
    } bpa_rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_LD,
        ST_BIT,
        ST_WR,
        ST_MSET,
        ST_FIN
    } bpa_state_t;

    typedef struct packed {
        logic init_wr;
        logic accept;
        logic rd;
        logic ld;
        logic bit_step;
        logic wr;
        logic mset;
        logic fin;
    } bpa_cmd_t;

    typedef struct packed {
        logic init_last;
        logic at_end;
        logic word_last;
        logic found;
        logic mark;
        logic out_free;
    } bpa_stat_t;

endpackage

/* hdl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hdl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: init sweep, word read/load, bit scan, write-back, result.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    bpa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (stat.init_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_RD;
            end
            ST_RD: begin
                state_next = stat.at_end ? ST_FIN : ST_LD;
            end
            ST_LD: state_next = ST_BIT;
            ST_BIT: begin
                if (stat.found) begin
                    state_next = ST_MSET;
                end else if (stat.word_last) begin
                    state_next = stat.mark ? ST_WR : ST_RD;
                end
            end
            ST_WR:   state_next = ST_RD;
            ST_MSET: state_next = ST_RD;
            ST_FIN: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: cmd.init_wr = 1'b1;
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_RD:   cmd.rd       = 1'b1;
            ST_LD:   cmd.ld       = 1'b1;
            ST_BIT:  cmd.bit_step = 1'b1;
            ST_WR:   cmd.wr       = 1'b1;
            ST_MSET: cmd.mset     = 1'b1;
            ST_FIN:  cmd.fin      = stat.out_free;
            default: cmd          = '0;
        endcase
    end

endmodule

/* hdl/bpa_dp.sv */
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: bitmap RAM, word register, page counter, run trackers, result.
// ----------------------------------------------------------------------------
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int unsigned PAGES = BPA_PAGES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  bpa_req_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output bpa_rsp_t    m_payload,
    input  bpa_cmd_t    cmd,
    output bpa_stat_t   stat
);

    localparam int unsigned WB    = BPA_WORD_BITS;
    localparam int unsigned WORDS = PAGES / WB;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned IW    = $clog2(PAGES) + 1;
    localparam int unsigned BW    = $clog2(WB);

    logic [12:0]   limit_reg;
    logic [12:0]   free_reg,  free_next;
    logic [IW-1:0] pg_reg,    pg_next;
    logic [IW-1:0] end_reg,   end_next;
    logic [IW-1:0] run_reg,   run_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] bstart_reg, bstart_next;
    logic [IW-1:0] blen_reg,  blen_next;
    logic          mark_reg,  mark_next;
    logic          hit_reg,   hit_next;
    logic [WB-1:0] word_reg,  word_next;
    logic [AW-1:0] waddr_reg, waddr_next;
    logic [1:0]    op_reg,    op_next;
    logic [12:0]   cnt_reg,   cnt_next;
    logic [13:0]   minp_reg,  minp_next;
    logic          imm_reg,   imm_next;
    logic          ovalid_reg, ovalid_next;
    bpa_rsp_t      out_reg,   out_next;

    logic [WB-1:0] rdata;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [WB-1:0] ram_wdata;

    logic [IW-1:0] lim;
    logic [IW-1:0] pg_inc;
    logic [BW-1:0] bsel;
    logic          ubit;
    logic [31:0]   free_hi;
    logic [IW-1:0] fin_len, fin_start;

    assign lim    = (32'(limit_reg) < 32'(PAGES)) ? IW'(limit_reg) : IW'(PAGES);
    assign pg_inc = pg_reg + 1'b1;
    assign bsel   = pg_reg[BW-1:0];
    assign ubit   = word_reg[bsel];
    assign fin_len   = (run_reg > blen_reg) ? run_reg : blen_reg;
    assign fin_start = (run_reg > blen_reg) ? start_reg : bstart_reg;
    assign free_hi   = 32'(s_payload.start_page) + 32'(s_payload.count);

    assign ram_we    = cmd.init_wr | cmd.wr;
    assign ram_addr  = cmd.wr ? waddr_reg : AW'(pg_reg >> BW);
    assign ram_wdata = cmd.init_wr ? '1 : word_reg;

    bpa_ram #(.WIDTH(WB), .DEPTH(WORDS), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    always_comb begin
        stat.init_last = (32'(pg_reg >> BW) == 32'(WORDS - 1));
        stat.at_end    = imm_reg | (pg_reg >= end_reg);
        stat.word_last = (&bsel) | (pg_inc >= end_reg);
        stat.found     = !mark_reg && (op_reg == OP_ALLOC) && !ubit
                         && (32'(run_reg) + 32'd1 == 32'(cnt_reg));
        stat.mark      = mark_reg;
        stat.out_free  = !ovalid_reg || m_ready;
    end

    always_comb begin
        free_next   = free_reg;
        pg_next     = pg_reg;
        end_next    = end_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        bstart_next = bstart_reg;
        blen_next   = blen_reg;
        mark_next   = mark_reg;
        hit_next    = hit_reg;
        word_next   = word_reg;
        waddr_next  = waddr_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        minp_next   = minp_reg;
        imm_next    = imm_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !m_ready;

        if (cmd.init_wr) begin
            pg_next = pg_reg + IW'(WB);
        end
        if (cmd.accept) begin
            op_next     = s_payload.opcode;
            cnt_next    = s_payload.count;
            minp_next   = 14'((26'(s_payload.min_bytes) + 26'd4095) >> BPA_PAGE_SHIFT);
            run_next    = '0;
            start_next  = '0;
            bstart_next = '0;
            blen_next   = '0;
            hit_next    = 1'b0;
            imm_next    = (s_payload.opcode == OP_NONE)
                       || ((s_payload.opcode == OP_ALLOC)
                           && ((s_payload.count == '0) || (free_reg < s_payload.count)));
            if (s_payload.opcode == OP_FREE) begin
                mark_next = 1'b1;
                pg_next   = IW'(s_payload.start_page);
                end_next  = (free_hi < 32'(lim)) ? IW'(free_hi) : lim;
                if (32'(s_payload.start_page) >= 32'(lim)) pg_next = lim;
            end else begin
                mark_next = 1'b0;
                pg_next   = '0;
                end_next  = lim;
            end
        end
        if (cmd.rd) begin
            waddr_next = AW'(pg_reg >> BW);
        end
        if (cmd.ld) begin
            word_next = rdata;
        end
        if (cmd.bit_step) begin
            pg_next = pg_inc;
            if (mark_reg) begin
                if (op_reg == OP_ALLOC) begin
                    word_next[bsel] = 1'b1;
                end else if (ubit) begin
                    word_next[bsel] = 1'b0;
                    free_next       = free_reg + 13'd1;
                end
            end else if (ubit) begin
                if (run_reg > blen_reg) begin
                    blen_next   = run_reg;
                    bstart_next = start_reg;
                end
                run_next = '0;
            end else begin
                if (run_reg == '0) start_next = pg_reg;
                run_next = run_reg + 1'b1;
                if (stat.found) hit_next = 1'b1;
            end
        end
        if (cmd.mset) begin
            mark_next = 1'b1;
            pg_next   = start_reg;
            end_next  = start_reg + IW'(cnt_reg);
        end
        if (cmd.fin) begin
            ovalid_next = 1'b1;
            out_next    = '0;
            out_next.status = 1'b1;
            case (op_reg)
                OP_ALLOC: begin
                    if (hit_reg) begin
                        out_next.status     = 1'b0;
                        out_next.page_index = 12'(32'(start_reg));
                        free_next           = free_reg - cnt_reg;
                    end
                end
                OP_FREE: out_next.status = 1'b0;
                OP_FIND: begin
                    if (32'(fin_len) >= 32'(minp_reg)) begin
                        out_next.status     = 1'b0;
                        out_next.page_index = 12'(32'(fin_start));
                        out_next.run_pages  = 13'(32'(fin_len));
                    end
                end
                default: out_next.status = 1'b1;
            endcase
            out_next.free_total = (cmd.fin && op_reg == OP_ALLOC && hit_reg)
                                ? free_reg - cnt_reg : free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= BPA_LIMIT_RST;
            free_reg   <= '0;
            pg_reg     <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            free_reg   <= free_next;
            pg_reg     <= pg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg    <= end_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        bstart_reg <= bstart_next;
        blen_reg   <= blen_next;
        mark_reg   <= mark_next;
        hit_reg    <= hit_next;
        word_reg   <= word_next;
        waddr_reg  <= waddr_next;
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        minp_reg   <= minp_next;
        imm_reg    <= imm_next;
        out_reg    <= out_next;
    end

    assign m_valid   = ovalid_reg;
    assign m_payload = out_reg;

endmodule

/* hdl/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit bitmap page allocator: alloc run, free range, find largest run.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to all-used, one 64-bit word per
// cycle, with s_ready low. Each request then walks the bitmap one page per
// clock in the bit scan, through a single-port RAM: every word costs a read, a
// load and a bit scan over up to 64 pages (plus a write-back on every word of a
// marking pass, i.e. free and the rewrite of an alloc). Find and a failed alloc
// scan up to the page limit; a successful alloc scans to the end of the run and
// then rewrites it; free visits only the freed range. Requests that need no
// scan go from the read state straight to the result. One request is in flight
// at a time; the result register lets the next request start while a result
// waits on m_ready.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int unsigned PAGES = BPA_PAGES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  bpa_req_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output bpa_rsp_t    m_payload
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_dp #(.PAGES(PAGES)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cmd         (cmd),
        .stat        (stat)
    );

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_payload.free_total) <= PAGES)
        else $error("free count above page total");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status) |->
            (m_payload.page_index == '0 && m_payload.run_pages == '0))
        else $error("failed result carries page data");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_payload.run_pages) <= PAGES)
        else $error("run longer than page total");

    a_init_block: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during bitmap init");
`endif

endmodule
